### src/hps_pkg.sv
package hps_pkg;

   // Result word format
   localparam int VAL_W   = 64;
   localparam int X_W     = 32;
   localparam int DEG_W   = 4;
   // Shared multiplier operand and product widths
   localparam int MUL_W   = 33;
   localparam int PROD_W  = 2 * MUL_W;
   // Accumulated x * He_(d-1) product, and the exact d * He_(d-1) product
   localparam int ACC_W   = PROD_W + 32;
   localparam int SLOPE_W = VAL_W + DEG_W + 2;
   localparam int DIFF_W  = ACC_W + 1;

   localparam logic [VAL_W-1:0] ONE_Q32 = 64'h0000_0001_0000_0000;
   localparam logic [VAL_W-1:0] SAT_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [VAL_W-1:0] SAT_MIN = 64'h8000_0000_0000_0000;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EMIT,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_COMBINE
   } hps_state_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_LOAD,
      OP_FIRST,
      OP_INC,
      OP_MUL_LO,
      OP_MUL_HI,
      OP_COMBINE
   } hps_op_type;

   typedef struct packed {
      hps_op_type op;
   } hps_ctrl_type;

   typedef struct packed {
      logic last;
      logic deg_zero;
   } hps_status_type;

   // Clamp a wide signed value to 64 bits; the top bit of the result flags clamping
   function automatic logic [VAL_W:0] sat64(input logic signed [DIFF_W-1:0] a);
      logic fits;
      fits = (&a[DIFF_W-1:VAL_W-1]) | ~(|a[DIFF_W-1:VAL_W-1]);
      if (fits) begin
         sat64 = {1'b0, a[VAL_W-1:0]};
      end else if (a[DIFF_W-1]) begin
         sat64 = {1'b1, SAT_MIN};
      end else begin
         sat64 = {1'b1, SAT_MAX};
      end
   endfunction

endpackage

### src/hermite_polynomial_series_unit.sv
// Probabilists' Hermite series unit: one request carries a point x (signed, X_FRAC_BITS
// fraction bits) and a top degree T (clamped to MAX_DEGREE); the unit answers with T+1
// responses for degrees 0..T in rising order, each holding He_d(x) and d*He_(d-1)(x) in
// signed Q32.32, saturated, with a sticky overflow flag and a last-of-run mark. Degree 0
// is answered from the load and degree 1 from one first step; every later degree runs three
// working steps (low half and high half of x*He_(d-1) on one shared 33x33 multiplier, then
// rescale, subtract and clamp) before its response. A new request is taken in the cycle
// after the last response.
module hermite_polynomial_series_unit
   import hps_pkg::*;
#(
   parameter int MAX_DEGREE  = 15,
   parameter int X_FRAC_BITS = 16
)
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic signed [X_W-1:0]   req_x_value,
   input  logic [DEG_W-1:0]        req_top_degree,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [DEG_W-1:0]        rsp_degree_index,
   output logic signed [VAL_W-1:0] rsp_poly_value,
   output logic signed [VAL_W-1:0] rsp_poly_slope,
   output logic                    rsp_overflow_seen,
   output logic                    rsp_last_of_run
);

   hps_ctrl_type   ctrl;
   hps_status_type status;

   hps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .ctrl      (ctrl)
   );

   hps_datapath #(
      .MAX_DEGREE  (MAX_DEGREE),
      .X_FRAC_BITS (X_FRAC_BITS)
   ) u_datapath (
      .clock             (clock),
      .ctrl              (ctrl),
      .status            (status),
      .req_x_value       (req_x_value),
      .req_top_degree    (req_top_degree),
      .rsp_degree_index  (rsp_degree_index),
      .rsp_poly_value    (rsp_poly_value),
      .rsp_poly_slope    (rsp_poly_slope),
      .rsp_overflow_seen (rsp_overflow_seen),
      .rsp_last_of_run   (rsp_last_of_run)
   );

   // No request is taken while a response is pending
   a_busy_while_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request accepted while a response is pending");

   // The run ends after its last response
   a_run_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_last_of_run) |=> (!rsp_valid && !req_stall))
      else $error("unit still busy after last response");

   // Degrees rise by one per response
   a_degree_step: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_last_of_run)
      |=> (rsp_degree_index == $past(rsp_degree_index) + DEG_W'(1)))
      else $error("degree did not advance by one");

   // Overflow stays raised for the rest of the run
   a_overflow_sticky: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_last_of_run && rsp_overflow_seen)
      |=> rsp_overflow_seen)
      else $error("overflow flag dropped inside a run");

endmodule

### src/hps_ctrl.sv
module hps_ctrl
   import hps_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   input  hps_status_type status,
   output hps_ctrl_type   ctrl
);

   hps_state_type state_ff, state_in;

   // Hold the sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Advance through the per-degree steps
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!rsp_stall) begin
               if (status.last) state_in = ST_IDLE;
               else if (status.deg_zero) state_in = ST_EMIT;
               else state_in = ST_MUL_LO;
            end
         end
         ST_MUL_LO:  state_in = ST_MUL_HI;
         ST_MUL_HI:  state_in = ST_COMBINE;
         ST_COMBINE: state_in = ST_EMIT;
         default:    state_in = ST_IDLE;
      endcase
   end

   // Drive handshake and datapath operation
   always_comb begin
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      ctrl.op   = OP_NONE;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) ctrl.op = OP_LOAD;
         end
         ST_EMIT: begin
            rsp_valid = 1'b1;
            if (!rsp_stall && !status.last) begin
               ctrl.op = status.deg_zero ? OP_FIRST : OP_INC;
            end
         end
         ST_MUL_LO:  ctrl.op = OP_MUL_LO;
         ST_MUL_HI:  ctrl.op = OP_MUL_HI;
         ST_COMBINE: ctrl.op = OP_COMBINE;
         default:    ctrl.op = OP_NONE;
      endcase
   end

endmodule

### src/hps_datapath.sv
module hps_datapath
   import hps_pkg::*;
#(
   parameter int MAX_DEGREE  = 15,
   parameter int X_FRAC_BITS = 16
)
(
   input  logic                    clock,
   input  hps_ctrl_type            ctrl,
   output hps_status_type          status,
   input  logic signed [X_W-1:0]   req_x_value,
   input  logic [DEG_W-1:0]        req_top_degree,
   output logic [DEG_W-1:0]        rsp_degree_index,
   output logic signed [VAL_W-1:0] rsp_poly_value,
   output logic signed [VAL_W-1:0] rsp_poly_slope,
   output logic                    rsp_overflow_seen,
   output logic                    rsp_last_of_run
);

   logic signed [X_W-1:0]     x_ff;
   logic [DEG_W-1:0]          top_ff, deg_ff, top_in;
   logic signed [VAL_W-1:0]   value_ff;
   logic signed [VAL_W-1:0]   slope_ff;
   logic signed [SLOPE_W-1:0] slope_ex_ff, slope_new_ff;
   logic signed [ACC_W-1:0]   acc_ff;
   logic                      ovf_ff, last_ff;

   logic signed [MUL_W-1:0]   mul_b;
   logic signed [PROD_W-1:0]  mul_p;
   logic signed [SLOPE_W-2:0] slope_prod;
   logic signed [ACC_W-1:0]   acc_sh;
   logic signed [DIFF_W-1:0]  diff;
   logic [VAL_W:0]            val_sat, slope_sat;

   // Clamp the requested top degree
   assign top_in = (int'(req_top_degree) > MAX_DEGREE) ? DEG_W'(MAX_DEGREE) : req_top_degree;

   // Shared multiplier: low half of He_(d-1) unsigned, then high half signed
   assign mul_b = (ctrl.op == OP_MUL_HI) ? {value_ff[VAL_W-1], value_ff[VAL_W-1:32]}
                                         : {1'b0, value_ff[31:0]};
   assign mul_p = $signed({x_ff[X_W-1], x_ff}) * mul_b;

   // Exact d * He_(d-1), a narrow multiple
   assign slope_prod = $signed({1'b0, deg_ff}) * value_ff;

   // Rescale the product, subtract (d-1) * He_(d-2) and clamp
   assign acc_sh    = acc_ff >>> X_FRAC_BITS;
   assign diff      = {acc_sh[ACC_W-1], acc_sh}
                      - {{(DIFF_W-SLOPE_W){slope_ex_ff[SLOPE_W-1]}}, slope_ex_ff};
   assign val_sat   = sat64(diff);
   assign slope_sat = sat64({{(DIFF_W-SLOPE_W){slope_new_ff[SLOPE_W-1]}}, slope_new_ff});

   // Run the selected step
   always_ff @(posedge clock) begin
      case (ctrl.op)
         OP_LOAD: begin
            x_ff     <= req_x_value;
            top_ff   <= top_in;
            deg_ff   <= '0;
            value_ff <= ONE_Q32;
            slope_ff <= '0;
            ovf_ff   <= 1'b0;
            last_ff  <= (top_in == '0);
         end
         OP_FIRST: begin
            deg_ff      <= DEG_W'(1);
            value_ff    <= {{(VAL_W-X_W){x_ff[X_W-1]}}, x_ff} << (32 - X_FRAC_BITS);
            slope_ff    <= ONE_Q32;
            slope_ex_ff <= SLOPE_W'(ONE_Q32);
            last_ff     <= (top_ff == DEG_W'(1));
         end
         OP_INC: begin
            deg_ff <= deg_ff + DEG_W'(1);
         end
         OP_MUL_LO: begin
            acc_ff       <= {{(ACC_W-PROD_W){mul_p[PROD_W-1]}}, mul_p};
            slope_new_ff <= {slope_prod[SLOPE_W-2], slope_prod};
         end
         OP_MUL_HI: begin
            acc_ff <= acc_ff + {mul_p, 32'b0};
         end
         OP_COMBINE: begin
            value_ff    <= val_sat[VAL_W-1:0];
            slope_ff    <= slope_sat[VAL_W-1:0];
            slope_ex_ff <= slope_new_ff;
            ovf_ff      <= ovf_ff | val_sat[VAL_W] | slope_sat[VAL_W];
            last_ff     <= (deg_ff == top_ff);
         end
         default: begin
         end
      endcase
   end

   assign status.last       = last_ff;
   assign status.deg_zero   = (deg_ff == '0);
   assign rsp_degree_index  = deg_ff;
   assign rsp_poly_value    = value_ff;
   assign rsp_poly_slope    = slope_ff;
   assign rsp_overflow_seen = ovf_ff;
   assign rsp_last_of_run   = last_ff;

endmodule

### tb/hermite_polynomial_series_checker.sv
`timescale 1ns / 1ps

module hermite_polynomial_series_checker
   import hps_pkg::*;
#(
   parameter int MAX_DEGREE  = 15,
   parameter int X_FRAC_BITS = 16
)
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_stall,
   input  logic signed [X_W-1:0]   req_x_value,
   input  logic [DEG_W-1:0]        req_top_degree,
   input  logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  logic [DEG_W-1:0]        rsp_degree_index,
   input  logic signed [VAL_W-1:0] rsp_poly_value,
   input  logic signed [VAL_W-1:0] rsp_poly_slope,
   input  logic                    rsp_overflow_seen,
   input  logic                    rsp_last_of_run,
   output int                      mismatch_count,
   output int                      terms_pending
);

   typedef struct {
      logic [DEG_W-1:0]        degree;
      logic signed [VAL_W-1:0] value;
      logic signed [VAL_W-1:0] slope;
      logic                    overflow;
      logic                    last;
   } hermite_term_type;

   hermite_term_type hermite_terms_due[$];

   // Clamp a wide signed value into Q32.32 range, raising the sticky flag on a clamp
   function automatic logic signed [VAL_W-1:0] clamp_q32(input logic signed [127:0] a,
                                                         inout logic ovf);
      if (a[127:VAL_W-1] == {(129-VAL_W){a[VAL_W-1]}}) begin
         return a[VAL_W-1:0];
      end
      ovf = 1'b1;
      return a[127] ? SAT_MIN : SAT_MAX;
   endfunction

   // Run the Hermite recurrence for one request and queue every degree it yields
   function automatic void queue_hermite_terms(input logic signed [X_W-1:0] x,
                                               input logic [DEG_W-1:0] top_in);
      logic signed [VAL_W-1:0] x_ext, prev1, prev2, val, slope;
      logic signed [127:0]     x_wide, p1_wide, p2_wide, k_wide, shifted, diff;
      logic                    ovf;
      int                      top;
      hermite_term_type        term;
      x_ext = x;
      prev1 = '0;
      prev2 = '0;
      ovf   = 1'b0;
      top   = (top_in > MAX_DEGREE) ? MAX_DEGREE : int'(top_in);
      for (int d = 0; d <= top; d++) begin
         if (d == 0) begin
            val   = ONE_Q32;
            slope = '0;
         end else if (d == 1) begin
            val   = x_ext <<< (32 - X_FRAC_BITS);
            slope = ONE_Q32;
         end else begin
            x_wide  = x_ext;
            p1_wide = prev1;
            p2_wide = prev2;
            // floor-rescale x*He(d-1), then subtract the exact (d-1)*He(d-2)
            shifted = (x_wide * p1_wide) >>> X_FRAC_BITS;
            k_wide  = d - 1;
            diff    = shifted - k_wide * p2_wide;
            val     = clamp_q32(diff, ovf);
            k_wide  = d;
            slope   = clamp_q32(k_wide * p1_wide, ovf);
         end
         term.degree   = d[DEG_W-1:0];
         term.value    = val;
         term.slope    = slope;
         term.overflow = ovf;
         term.last     = (d == top);
         hermite_terms_due.push_back(term);
         prev2 = prev1;
         prev1 = val;
      end
   endfunction

   task automatic check_field(input string field, input logic [VAL_W-1:0] want,
                              input logic [VAL_W-1:0] got, input logic [DEG_W-1:0] deg);
      if (want !== got) begin
         $display("%0t: degree %0d %s: expected %h, actual %h", $time, deg, field, want, got);
         mismatch_count++;
      end
   endtask

   // Predict on each accepted request, compare each accepted response with the oldest term
   always @(posedge clock) begin
      hermite_term_type head;
      if (reset) begin
         mismatch_count = 0;
      end else begin
         if (req_valid && !req_stall) begin
            queue_hermite_terms(req_x_value, req_top_degree);
         end
         if (rsp_valid && !rsp_stall) begin
            if (hermite_terms_due.size() == 0) begin
               $display("%0t: response with none expected: degree %0d value %h slope %h",
                        $time, rsp_degree_index, rsp_poly_value, rsp_poly_slope);
               mismatch_count++;
            end else begin
               head = hermite_terms_due.pop_front();
               check_field("degree_index", head.degree, rsp_degree_index, head.degree);
               check_field("poly_value", head.value, rsp_poly_value, head.degree);
               check_field("poly_slope", head.slope, rsp_poly_slope, head.degree);
               check_field("overflow_seen", head.overflow, rsp_overflow_seen, head.degree);
               check_field("last_of_run", head.last, rsp_last_of_run, head.degree);
            end
         end
      end
      terms_pending <= hermite_terms_due.size();
   end

endmodule

### tb/hermite_polynomial_series_unit_tb.sv
`timescale 1ns / 1ps

module hermite_polynomial_series_unit_tb;
   import hps_pkg::*;

   localparam int DIRECTED_COUNT = 22;
   localparam int RANDOM_COUNT   = 400;
   localparam int MAX_IDLE       = 16;

   // Directed requests as {x, top degree}
   localparam logic [X_W+DEG_W-1:0] DIRECTED_REQS [DIRECTED_COUNT] = '{
      {32'h0000_0000, 4'd0},  {32'h0001_0000, 4'd15}, {32'hFFFF_0000, 4'd15},
      {32'h0000_0000, 4'd15}, {32'h0002_0000, 4'd15}, {32'h7FFF_FFFF, 4'd15},
      {32'h8000_0000, 4'd15}, {32'h0000_0001, 4'd15}, {32'hFFFF_FFFF, 4'd15},
      {32'h0000_8000, 4'd5},  {32'hFFFF_8000, 4'd7},  {32'h7FFF_FFFF, 4'd0},
      {32'h8000_0000, 4'd1},  {32'h8000_0000, 4'd2},  {32'h0001_A000, 4'd15},
      {32'hFFFE_6000, 4'd15}, {32'h0030_0000, 4'd15}, {32'h000A_0000, 4'd15},
      {32'h0004_0000, 4'd15}, {32'hFFFC_0000, 4'd12}, {32'h1234_5678, 4'd3},
      {32'hEDCB_A987, 4'd4}
   };

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic signed [X_W-1:0]   req_x_value = '0;
   logic [DEG_W-1:0]        req_top_degree = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic [DEG_W-1:0]        rsp_degree_index;
   logic signed [VAL_W-1:0] rsp_poly_value;
   logic signed [VAL_W-1:0] rsp_poly_slope;
   logic                    rsp_overflow_seen;
   logic                    rsp_last_of_run;
   int                      mismatch_count;
   int                      terms_pending;
   logic                    quiet_stretch = 1'b0;

   always #4 clock = ~clock;

   hermite_polynomial_series_unit i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_x_value       (req_x_value),
      .req_top_degree    (req_top_degree),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_degree_index  (rsp_degree_index),
      .rsp_poly_value    (rsp_poly_value),
      .rsp_poly_slope    (rsp_poly_slope),
      .rsp_overflow_seen (rsp_overflow_seen),
      .rsp_last_of_run   (rsp_last_of_run)
   );

   hermite_polynomial_series_checker i_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_x_value       (req_x_value),
      .req_top_degree    (req_top_degree),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_degree_index  (rsp_degree_index),
      .rsp_poly_value    (rsp_poly_value),
      .rsp_poly_slope    (rsp_poly_slope),
      .rsp_overflow_seen (rsp_overflow_seen),
      .rsp_last_of_run   (rsp_last_of_run),
      .mismatch_count    (mismatch_count),
      .terms_pending     (terms_pending)
   );

   // Randomly stall the response side before each response, except in quiet stretches
   initial begin
      int hold;
      while (reset) @(posedge clock);
      forever begin
         hold = quiet_stretch ? 0 : $urandom_range(0, MAX_IDLE);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
      end
   end

   // Drive directed then random requests, then drain and report
   initial begin
      int                    gap;
      logic signed [X_W-1:0] x_next;
      logic [DEG_W-1:0]      deg_next;
      logic signed [X_W-1:0] raw;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      for (int i = 0; i < DIRECTED_COUNT + RANDOM_COUNT; i++) begin
         // every third stretch of 40 requests runs with no idling on either side
         quiet_stretch = ((i / 40) % 3) == 1;
         if (i < DIRECTED_COUNT) begin
            {x_next, deg_next} = DIRECTED_REQS[i];
         end else begin
            raw = $urandom;
            x_next = ($urandom_range(0, 3) == 0) ? raw : (raw >>> $urandom_range(8, 30));
            deg_next = DEG_W'($urandom_range(0, 15));
         end
         gap = quiet_stretch ? 0 : $urandom_range(0, MAX_IDLE);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_valid      <= 1'b1;
         req_x_value    <= x_next;
         req_top_degree <= deg_next;
         do @(posedge clock); while (req_stall);
      end
      req_valid <= 1'b0;
      // wait out the outstanding terms, then a settle window for stray responses
      do @(posedge clock); while (terms_pending != 0);
      repeat (80) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("hermite_polynomial_series_unit: match");
      end else begin
         $display("hermite_polynomial_series_unit: mismatch");
      end
      $finish;
   end

   // Abort a hung run
   initial begin
      #10_000_000;
      $display("hermite_polynomial_series_unit: mismatch");
      $finish;
   end

endmodule
